/* hdl/sobm_pkg.sv */
// Shared constants and controller/datapath interface types for the Shift-Or byte matcher.
`timescale 1ns / 1ps
package sobm_pkg;

    localparam int ALPHA_SIZE = 256;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int PIDX_W     = 5;
    localparam int LEN_W      = 6;
    localparam int TPOS_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 64;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_SCAN = 1'b1;

    typedef struct packed {
        logic take;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

/* hdl/shift_or_byte_matcher_core.sv */
// Top level of the Shift-Or byte matcher: stream ports, controller and datapath.
//
// Requests arrive on the slave stream. tuser selects the kind: 0 loads a
// pattern byte, 1 scans a text byte. tdata carries the byte in bits 7:0 and
// the pattern index in bits 12:8; tlast marks the final byte of a text.
// A load at index zero restarts the pattern and the scan state.
// Every request yields one result on the master stream: tuser is the match
// flag, tdata holds the match start in bits 31:0 and the running count in
// bits 63:32.
// The user must write the pattern length register through the cfg channel only
// while the block is idle; the block does not enforce this. The cfg channel is
// always ready. Each request first reads the mask memory as it is taken, then
// updates the match word and fills the output register in the execute state; a
// new request is taken only after the previous one has executed.
// The output register holds a result until it is taken; a stalled receiver
// holds the next request in its execute cycle. Reset empties the output,
// marks every mask entry as all ones and restores a length of one.
`timescale 1ns / 1ps
module shift_or_byte_matcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // data_byte[7:0], position[12:8], zero pad
    input  logic        s_axis_tuser,  // req_type
    input  logic        s_axis_tlast,  // last_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // match_start[31:0], match_count[63:32]
    output logic        m_axis_tuser,  // match
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);
    import sobm_pkg::*;

    t_cmd               cmd;
    t_status            status;
    logic [TPOS_W-1:0]  match_start;
    logic [COUNT_W-1:0] match_count;

    sobm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sobm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_req_type    (s_axis_tuser),
        .i_data_byte   (s_axis_tdata[BYTE_W-1:0]),
        .i_position    (s_axis_tdata[BYTE_W+PIDX_W-1:BYTE_W]),
        .i_last_text   (s_axis_tlast),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_len     (i_cfg_data),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_match       (m_axis_tuser),
        .o_match_start (match_start),
        .o_match_count (match_count)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {match_count, match_start};

endmodule

/* hdl/sobm_ctrl.sv */
// Controller state machine that sequences request intake and execution.
`timescale 1ns / 1ps
module sobm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  sobm_pkg::t_status i_status,
    output sobm_pkg::t_cmd   o_cmd
);
    import sobm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd.take  = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/sobm_datapath.sv */
// Datapath with the mask memory, match word, counters and output register.
`timescale 1ns / 1ps
module sobm_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sobm_pkg::t_cmd                   i_cmd,
    output sobm_pkg::t_status                o_status,
    input  logic                             i_req_type,
    input  logic [sobm_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic [sobm_pkg::PIDX_W-1:0]      i_position,
    input  logic                             i_last_text,
    input  logic                             i_cfg_we,
    input  logic [sobm_pkg::LEN_W-1:0]       i_cfg_len,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_match,
    output logic [sobm_pkg::TPOS_W-1:0]      o_match_start,
    output logic [sobm_pkg::COUNT_W-1:0]     o_match_count
);
    import sobm_pkg::*;

    logic [WORD_W-1:0]     r_mem [ALPHA_SIZE];
    logic [WORD_W-1:0]     r_rd_data;
    logic [ALPHA_SIZE-1:0] r_entry_ok;

    logic                  r_req_type;
    logic [BYTE_W-1:0]     r_byte;
    logic [PIDX_W-1:0]     r_pidx;
    logic                  r_last;
    logic [LEN_W-1:0]      r_len_cfg;

    logic [WORD_W-1:0]     r_word;
    logic [TPOS_W-1:0]     r_tpos;
    logic [COUNT_W-1:0]    r_count;

    logic                  r_out_valid;
    logic                  r_out_match;
    logic [TPOS_W-1:0]     r_out_start;
    logic [COUNT_W-1:0]    r_out_count;

    logic [LEN_W-1:0]      len;
    logic [PIDX_W-1:0]     len_m1;
    logic [WORD_W-1:0]     mask;
    logic [WORD_W-1:0]     base;
    logic [WORD_W-1:0]     wr_data;
    logic                  wr_en;
    logic [WORD_W-1:0]     n_word;
    logic                  hit;
    logic [COUNT_W-1:0]    n_count;
    logic [TPOS_W-1:0]     start;

    always_comb begin
        if (r_len_cfg == '0) begin
            len = LEN_W'(1);
        end else if (r_len_cfg > LEN_W'(WORD_W)) begin
            len = LEN_W'(WORD_W);
        end else begin
            len = r_len_cfg;
        end
        len_m1  = PIDX_W'(len - LEN_W'(1));
        mask    = r_entry_ok[r_byte] ? r_rd_data : '1;
        base    = (r_pidx == '0) ? '1 : mask;
        wr_data = base & ~(WORD_W'(1) << r_pidx);
        wr_en   = i_cmd.exec && (r_req_type == REQ_LOAD)
                  && ({1'b0, r_pidx} < len);
        n_word  = {r_word[WORD_W-2:0], 1'b0} | mask;
        hit     = !n_word[len_m1];
        n_count = (hit && (r_count != '1)) ? r_count + COUNT_W'(1) : r_count;
        start   = r_tpos + TPOS_W'(1) - TPOS_W'(len);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rd_data <= r_mem[i_data_byte];
        end
        if (wr_en) begin
            r_mem[r_byte] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req_type <= i_req_type;
            r_byte     <= i_data_byte;
            r_pidx     <= i_position;
            r_last     <= i_last_text;
        end
        if (i_cmd.exec) begin
            r_out_match <= (r_req_type == REQ_SCAN) && hit;
            r_out_start <= ((r_req_type == REQ_SCAN) && hit) ? start : '0;
            if (r_req_type == REQ_SCAN) begin
                r_out_count <= n_count;
            end else if (r_pidx == '0) begin
                r_out_count <= '0;
            end else begin
                r_out_count <= r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_ok  <= '0;
            r_len_cfg   <= LEN_W'(1);
            r_word      <= '1;
            r_tpos      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len_cfg <= i_cfg_len;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec && (r_req_type == REQ_LOAD)) begin
                if (r_pidx == '0) begin
                    r_entry_ok <= ALPHA_SIZE'(1) << r_byte;
                    r_word     <= '1;
                    r_tpos     <= '0;
                    r_count    <= '0;
                end else if (wr_en) begin
                    r_entry_ok[r_byte] <= 1'b1;
                end
            end
            if (i_cmd.exec && (r_req_type == REQ_SCAN)) begin
                if (r_last) begin
                    r_word  <= '1;
                    r_tpos  <= '0;
                    r_count <= '0;
                end else begin
                    r_word  <= n_word;
                    r_count <= n_count;
                    if (r_tpos != '1) begin
                        r_tpos <= r_tpos + TPOS_W'(1);
                    end
                end
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_match           = r_out_match;
    assign o_match_start     = r_out_start;
    assign o_match_count     = r_out_count;

endmodule

/* tb/sv/tb.sv */
// Testbench for the Shift-Or byte matcher core: stream stimulus, matcher scoreboard and checks.
`timescale 1ns / 1ps
module tb;
    import sobm_pkg::*;

    localparam int IDLE_LIMIT      = 5000;
    localparam int TARGET_REQUESTS = 650;
    localparam int LONG_HOLD       = 80;
    localparam int PAD_W           = S_DATA_W - PIDX_W - BYTE_W;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] data_byte;
        logic [PIDX_W-1:0] position;
        logic              last_text;
    } t_text_request;

    typedef struct packed {
        logic               hit;
        logic [TPOS_W-1:0]  start;
        logic [COUNT_W-1:0] count;
    } t_match_result;

    class match_scoreboard;
        logic [WORD_W-1:0]  mask_tab [ALPHA_SIZE];
        logic [WORD_W-1:0]  match_word;
        logic [TPOS_W-1:0]  text_pos;
        logic [COUNT_W-1:0] occ_count;
        logic [LEN_W-1:0]   pat_len;
        t_match_result      pending_results[$];
        int                 errors;

        function new();
            foreach (mask_tab[i]) mask_tab[i] = '1;
            restart_scan();
            pat_len = LEN_W'(1);
            errors  = 0;
        endfunction

        function void restart_scan();
            match_word = '1;
            text_pos   = '0;
            occ_count  = '0;
        endfunction

        function void set_length(logic [LEN_W-1:0] value);
            pat_len = value;
        endfunction

        function int active_length();
            if (pat_len == 0) return 1;
            if (pat_len > WORD_W) return WORD_W;
            return int'(pat_len);
        endfunction

        function void note_request(t_text_request r);
            int                len;
            logic [TPOS_W-1:0] len_v;
            t_match_result     res;
            len   = active_length();
            len_v = TPOS_W'(len);
            res   = '0;
            if (r.req_type == REQ_LOAD) begin
                if (r.position == 0) begin
                    foreach (mask_tab[i]) mask_tab[i] = '1;
                    restart_scan();
                end
                if (int'(r.position) < len) mask_tab[r.data_byte][r.position] = 1'b0;
                res.count = occ_count;
            end else begin
                match_word = (match_word << 1) | mask_tab[r.data_byte];
                if (match_word[len-1] == 1'b0) begin
                    res.hit   = 1'b1;
                    res.start = text_pos + 1 - len_v;
                    if (occ_count != '1) occ_count++;
                end
                res.count = occ_count;
                if (text_pos != '1) text_pos++;
                if (r.last_text) restart_scan();
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic hit, logic [TPOS_W-1:0] start,
                                   logic [COUNT_W-1:0] count);
            t_match_result exp_res;
            if (pending_results.size() == 0) begin
                $error("result with none pending: match %0d match_start %0d match_count %0d",
                       hit, start, count);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (hit !== exp_res.hit) begin
                $error("match: expected %0d, actual %0d", exp_res.hit, hit);
                errors++;
            end
            if (start !== exp_res.start) begin
                $error("match_start: expected %0d, actual %0d", exp_res.start, start);
                errors++;
            end
            if (count !== exp_res.count) begin
                $error("match_count: expected %0d, actual %0d", exp_res.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                s_axis_tuser;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [LEN_W-1:0]    i_cfg_data;

    match_scoreboard sb = new();
    int              sent_count = 0;
    int              rx_hold = 0;
    int              idle_cycles = 0;
    bit              tx_no_gaps = 1'b0;

    shift_or_byte_matcher_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic send_request(t_text_request r);
        int gap;
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {{PAD_W{1'b0}}, r.position, r.data_byte};
        s_axis_tuser  = r.req_type;
        s_axis_tlast  = r.last_text;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_request(r);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic load_byte(logic [BYTE_W-1:0] b, logic [PIDX_W-1:0] p, logic last);
        send_request('{REQ_LOAD, b, p, last});
    endtask

    task automatic scan_byte(logic [BYTE_W-1:0] b, logic last);
        send_request('{REQ_SCAN, b, PIDX_W'($urandom_range(0, 31)), last});
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] value);
        wait_drained();
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_length(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // The receiver stalls at random; a long hold requested by the stimulus overrides that.
    initial begin
        int stall;
        bit steady;
        stall  = 0;
        steady = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else if (stall == 0 && $urandom_range(0, 49) == 0) begin
                steady = !steady;
            end
            if (stall == 0 && !steady && $urandom_range(0, 2) == 0) stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
            end
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[TPOS_W-1:0],
                                m_axis_tdata[M_DATA_W-1:TPOS_W]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("shift_or_byte_matcher_core: mismatch");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] alpha [4];
        logic [BYTE_W-1:0] pat [WORD_W];
        logic [LEN_W-1:0]  len;
        int                phase;
        int                r;
        int                n_texts;
        int                text_len;
        int                k;
        phase         = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LOAD;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        foreach (pat[i]) pat[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty table, single-byte pattern, ignored loads, end of text.
        scan_byte(8'hFF, 1'b0);
        load_byte(8'hFF, 5'd0, 1'b0);
        load_byte(8'h00, 5'd31, 1'b1);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b1);
        scan_byte(8'hFF, 1'b0);
        // Longer length without a reload keeps the scan state running.
        write_length(6'd2);
        load_byte(8'hA5, 5'd1, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'hA5, 1'b0);
        scan_byte(8'h5A, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'hA5, 1'b1);
        load_byte(8'h5A, 5'd0, 1'b0);
        load_byte(8'hA5, 5'd1, 1'b0);
        scan_byte(8'h5A, 1'b0);
        scan_byte(8'hA5, 1'b0);
        scan_byte(8'h5A, 1'b0);
        scan_byte(8'hA5, 1'b1);

        while (sent_count < TARGET_REQUESTS) begin
            case (phase)
                0: len = LEN_W'(WORD_W);
                1: len = LEN_W'(1);
                default: begin
                    r = $urandom_range(0, 9);
                    if (r < 2) len = LEN_W'(1);
                    else if (r < 4) len = LEN_W'(WORD_W);
                    else len = LEN_W'($urandom_range(2, WORD_W - 1));
                end
            endcase
            write_length(len);
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            foreach (alpha[i]) alpha[i] = BYTE_W'($urandom_range(0, 255));
            if (phase < 2 || $urandom_range(0, 9) != 0) begin
                for (int p = 0; p < len; p++) begin
                    pat[p] = alpha[$urandom_range(0, 3)];
                    load_byte(pat[p], PIDX_W'(p), $urandom_range(0, 7) == 0);
                    if ($urandom_range(0, 9) == 0)
                        load_byte(BYTE_W'($urandom_range(0, 255)),
                                  PIDX_W'($urandom_range(1, 31)), 1'b0);
                end
            end
            if (phase == 2) begin
                rx_hold    = LONG_HOLD;
                tx_no_gaps = 1'b1;
            end
            n_texts = $urandom_range(1, 4);
            for (int t = 0; t < n_texts && sent_count < TARGET_REQUESTS; t++) begin
                text_len = $urandom_range(1, 2 * len + 8);
                k = 0;
                while (k < text_len && sent_count < TARGET_REQUESTS) begin
                    r = $urandom_range(0, 99);
                    if (r < 25 && k + len <= text_len) begin
                        for (int q = 0; q < len; q++) scan_byte(pat[q], k + q == text_len - 1);
                        k += len;
                    end else if (r < 28) begin
                        load_byte(BYTE_W'($urandom_range(0, 255)),
                                  PIDX_W'($urandom_range(1, 31)), 1'b0);
                    end else begin
                        scan_byte((r < 85) ? alpha[$urandom_range(0, 3)]
                                           : BYTE_W'($urandom_range(0, 255)),
                                  k == text_len - 1);
                        k++;
                    end
                end
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("shift_or_byte_matcher_core: match");
        end else begin
            $display("shift_or_byte_matcher_core: mismatch");
        end
        $finish;
    end

endmodule

/* shift_or_byte_matcher_core.f */
hdl/sobm_pkg.sv
hdl/sobm_ctrl.sv
hdl/sobm_datapath.sv
hdl/shift_or_byte_matcher_core.sv
tb/sv/tb.sv
